// ----- src/rde_pkg.sv -----
// Shared types, constants and helper functions for the radix digit emitter.
package rde_pkg;

  // Input bits consumed by the remainder unit in one clock cycle.
  localparam int CHUNK = 8;

  // Digit counts fit in this width for value widths up to 64 bits.
  localparam int CNT_W = 7;

  // Widths of one digit (remainder) and of one output character.
  localparam int DIGIT_W = 4;
  localparam int CHAR_W = 7;
  localparam int RADIX_W = 5;

  // Legal radix range and the radix after reset.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // ASCII codes for the digits 0-9 and a-f.
  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
    7'd56, 7'd57, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102
  };

  // Hand-off of one finished digit string from the front to the back.
  typedef struct packed {
    logic             push;
    logic             bank;
    logic [CNT_W-1:0] count;
  } push_t;

  // Release of one digit buffer bank by the back.
  typedef struct packed {
    logic pop;
    logic bank;
  } pop_t;

  // Map a remainder to its lower-case ASCII digit.
  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

  // Saturate the radix register into the legal range.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

// ----- src/radix_digit_emitter.sv -----
// Top level of the radix digit emitter: radix register, bank queue and the two engines.
//
// Converts an unsigned value to its lower-case digit string in a radix from 2 to 16
// (register writes outside that range saturate) and delivers the digits most
// significant first, one per strobe, with last set on the least significant digit.
// Zero gives the single digit '0'. The receiver cannot stall: every strobe is a
// transfer. The front end's remainder unit consumes 8 bits of the value per cycle,
// so each digit takes a full pass over the value, and busy stays high until the
// last digit of a value is written. Finished strings wait in one of two digit
// buffer banks; the back end reads them out at one digit per cycle once it has
// loaded the digit index, while the front end converts the next value. busy also
// stays high while both banks hold strings not yet emitted. No clearing pass
// follows reset.
module radix_digit_emitter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_WIDTH-1:0]      value,
  input  logic                        radix_we,
  input  logic [rde_pkg::RADIX_W-1:0] radix_data,
  output logic [rde_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last,
  output logic                        digit_strobe
);
  import rde_pkg::*;

  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH = 2 ** ADDR_W;

  logic [RADIX_W-1:0] radix_q;
  logic [1:0]         bank_full;
  logic [CNT_W-1:0]   bank_count [2];

  logic               start_accept;
  logic               front_active;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] rd_data;
  push_t              push;
  pop_t               pop;

  // A new value is taken when the front end is idle and its next bank is free.
  assign busy = front_active || bank_full[push.bank];
  assign start_accept = start && !busy;

  // Radix register and bank occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_q <= RADIX_RESET;
      bank_full <= '0;
    end else begin
      if (radix_we) begin
        radix_q <= radix_data;
      end
      if (push.push) begin
        bank_full[push.bank] <= 1'b1;
      end
      if (pop.pop) begin
        bank_full[pop.bank] <= 1'b0;
      end
    end
  end

  // Digit count of each filled bank.
  always_ff @(posedge clk) begin
    if (push.push) begin
      bank_count[push.bank] <= push.count;
    end
  end

  rde_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start_accept (start_accept),
    .value        (value),
    .radix_eff    (eff_radix(radix_q)),
    .active       (front_active),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push)
  );

  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rde_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .bank_full  (bank_full),
    .bank_count (bank_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .pop        (pop),
    .digit_char (digit_char),
    .last       (last),
    .strobe     (digit_strobe)
  );

`ifndef NO_ASSERTIONS
  // The front end never hands over a bank that still holds a string.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !bank_full[push.bank])
    else $error("digit string pushed into an occupied bank");

  // The back end only releases a bank that holds a string.
  a_pop_full: assert property (@(posedge clk) disable iff (rst)
    pop.pop |-> bank_full[pop.bank])
    else $error("release of an empty digit bank");

  // With both banks occupied no new value may be taken.
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (bank_full == 2'b11) |-> busy)
    else $error("value accepted while both digit banks are occupied");

  // The digit that ends a string is followed by an idle cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (digit_strobe && last) |=> !digit_strobe)
    else $error("result transfer directly after the last digit");
`endif

endmodule

// ----- src/rde_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rde_front.sv -----
// Front end: accepts a value and divides it down by the radix, storing each digit.
module rde_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start_accept,
  input  logic [VALUE_WIDTH-1:0]            value,
  input  logic [rde_pkg::RADIX_W-1:0]       radix_eff,
  output logic                              active,
  output logic                              wr_en,
  output logic [$clog2(VALUE_WIDTH):0]      wr_addr,
  output logic [rde_pkg::DIGIT_W-1:0]       wr_data,
  output rde_pkg::push_t                    push
);
  import rde_pkg::*;

  localparam int NCHUNK = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PAD_W = NCHUNK * CHUNK;
  localparam int CHK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(NCHUNK - 1);

  logic [PAD_W-1:0]   quo;
  logic [DIGIT_W-1:0] rem;
  logic [RADIX_W-1:0] rad;
  logic [CHK_W-1:0]   chunk;
  logic [IDX_W-1:0]   ndig;
  logic               nz;
  logic               wr_bank;

  logic [DIGIT_W-1:0] rem_next;
  logic [CHUNK-1:0]   qbits;
  logic [RADIX_W-1:0] trial;
  logic               digit_done;
  logic               quo_nonzero;

  // Remainder unit: eight restoring division steps per cycle, top bits first.
  always_comb begin
    rem_next = rem;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < CHUNK; i++) begin
      trial = {rem_next, quo[PAD_W-1-i]};
      if (trial >= rad) begin
        trial = trial - rad;
        qbits[CHUNK-1-i] = 1'b1;
      end
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  assign digit_done = active && (chunk == LAST_CHUNK);
  assign quo_nonzero = nz || (|qbits);

  // The finished remainder is written into the current bank at the digit index.
  assign wr_en = digit_done;
  assign wr_addr = {wr_bank, ndig};
  assign wr_data = rem_next;

  // A zero quotient ends the string and hands the bank to the back end.
  always_comb begin
    push.push = digit_done && !quo_nonzero;
    push.bank = wr_bank;
    push.count = CNT_W'(ndig) + CNT_W'(1);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      wr_bank <= 1'b0;
    end else if (start_accept) begin
      active <= 1'b1;
    end else if (digit_done && !quo_nonzero) begin
      active <= 1'b0;
      wr_bank <= ~wr_bank;
    end
  end

  // Quotient, remainder and counters.
  always_ff @(posedge clk) begin
    if (start_accept) begin
      quo <= PAD_W'(value);
      rem <= '0;
      rad <= radix_eff;
      chunk <= '0;
      ndig <= '0;
      nz <= 1'b0;
    end else if (active) begin
      quo <= (quo << CHUNK) | PAD_W'(qbits);
      if (digit_done) begin
        rem <= '0;
        chunk <= '0;
        nz <= 1'b0;
        ndig <= ndig + IDX_W'(1);
      end else begin
        rem <= rem_next;
        chunk <= chunk + CHK_W'(1);
        nz <= quo_nonzero;
      end
    end
  end

endmodule

// ----- src/rde_back.sv -----
// Back end: reads a finished digit string out most significant digit first.
module rde_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        bank_full,
  input  logic [rde_pkg::CNT_W-1:0]         bank_count [2],
  output logic                              rd_en,
  output logic [$clog2(VALUE_WIDTH):0]      rd_addr,
  input  logic [rde_pkg::DIGIT_W-1:0]       rd_data,
  output rde_pkg::pop_t                     pop,
  output logic [rde_pkg::CHAR_W-1:0]        digit_char,
  output logic                              last,
  output logic                              strobe
);
  import rde_pkg::*;

  localparam int IDX_W = $clog2(VALUE_WIDTH);

  logic             emitting;
  logic             rd_bank;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt_m1;

  assign cnt_m1 = bank_count[rd_bank] - CNT_W'(1);

  // One read per cycle while a string is being emitted.
  assign rd_en = emitting;
  assign rd_addr = {rd_bank, idx};

  // The bank is released when its final digit has been read.
  always_comb begin
    pop.pop = emitting && (idx == '0);
    pop.bank = rd_bank;
  end

  // Read sequencer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      rd_bank <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= emitting;
      if (emitting) begin
        if (idx == '0) begin
          emitting <= 1'b0;
          rd_bank <= ~rd_bank;
        end
      end else if (bank_full[rd_bank]) begin
        emitting <= 1'b1;
      end
    end
  end

  // Digit index counts down from the most significant digit.
  always_ff @(posedge clk) begin
    if (emitting) begin
      idx <= idx - IDX_W'(1);
      last <= (idx == '0);
    end else begin
      idx <= cnt_m1[IDX_W-1:0];
    end
  end

  // The character follows the registered RAM output.
  assign digit_char = digit_char_of(rd_data);

`ifndef NO_ASSERTIONS
  // Every strobe follows a read issued in the cycle before.
  a_strobe_after_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(rd_en))
    else $error("result strobe without a preceding digit read");
`endif

endmodule

// ----- test/tb_radix_digit_emitter.sv -----
// Self-checking testbench for the radix digit emitter top level.
module tb_radix_digit_emitter;
  import rde_pkg::*;

  localparam int VW = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Longest conversion is 32 binary digits, each a full pass over the value, plus setup.
  localparam int TAIL_CYCLES = 150;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES = 9;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  // Predicts the digit string of each accepted value and checks emitted digits in order.
  class digit_scoreboard;
    logic [RADIX_W-1:0] radix_setting;
    digit_t             expected_digits[$];
    int unsigned        errors;
    int unsigned        values_seen;
    int unsigned        digits_seen;

    function new();
      radix_setting = RADIX_RESET;
      errors = 0;
      values_seen = 0;
      digits_seen = 0;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] r);
      radix_setting = r;
    endfunction

    // Register values outside two to sixteen are clamped to the nearest bound.
    function int unsigned base();
      int unsigned b;
      b = radix_setting;
      if (b < RADIX_MIN) begin
        b = RADIX_MIN;
      end else if (b > RADIX_MAX) begin
        b = RADIX_MAX;
      end
      return b;
    endfunction

    function logic [CHAR_W-1:0] char_of(int unsigned d);
      logic [CHAR_W-1:0] c;
      if (d < 10) begin
        c = CHAR_ZERO + d[CHAR_W-1:0];
      end else begin
        c = CHAR_LOWER_A + d[CHAR_W-1:0] - 7'd10;
      end
      return c;
    endfunction

    // Divide repeatedly; remainders arrive least significant first and are queued reversed.
    function void note_value(logic [VW-1:0] v);
      logic [VW-1:0] rest;
      int unsigned   b;
      int unsigned   d;
      digit_t        dg;
      digit_t        lsd_first[$];
      b = base();
      rest = v;
      do begin
        d = rest % b;
        dg.ch = char_of(d);
        dg.last = 1'b0;
        lsd_first.push_back(dg);
        rest = rest / b;
      end while (rest != 0);
      lsd_first[0].last = 1'b1;
      while (lsd_first.size() != 0) begin
        expected_digits.push_back(lsd_first.pop_back());
      end
      values_seen++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_digit(logic [CHAR_W-1:0] ch, logic is_last);
      digit_t want;
      digits_seen++;
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("digit 0x%02h last=%0b with nothing pending", ch, is_last));
      end else begin
        want = expected_digits.pop_front();
        if (ch !== want.ch) begin
          report_mismatch($sformatf("digit_char 0x%02h, wanted 0x%02h", ch, want.ch));
        end
        if (is_last !== want.last) begin
          report_mismatch($sformatf("last %0b, wanted %0b", is_last, want.last));
        end
      end
    endtask

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [VW-1:0]      value = '0;
  logic               radix_we = 1'b0;
  logic [RADIX_W-1:0] radix_data = '0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;
  logic               digit_strobe;

  digit_scoreboard    sb = new();
  int unsigned        cycle_count = 0;
  int unsigned        settings_used = 0;

  radix_digit_emitter #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .radix_we    (radix_we),
    .radix_data  (radix_data),
    .digit_char  (digit_char),
    .last        (last),
    .digit_strobe(digit_strobe)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input transfers and digit strobes are sampled at the edge that completes them.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_value(value);
    end
    if (!rst && digit_strobe) begin
      sb.check_digit(digit_char, last);
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present a value and hold start until the transfer; start stays high afterwards.
  task send_value(logic [VW-1:0] v);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Random sender idle before the next item.
  task sender_gap(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      value <= $urandom();
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < pct);
    end
  endtask

  // Stop sending and wait until every pending digit has come out and the block is free.
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  task write_radix(logic [RADIX_W-1:0] r);
    radix_we <= 1'b1;
    radix_data <= r;
    sb.set_radix(r);
    settings_used++;
    @(posedge clk);
    radix_we <= 1'b0;
  endtask

  // Mix of small values, near-full values, single bits, radix powers and plain random.
  function logic [VW-1:0] random_value();
    longint unsigned pw;
    int unsigned     b;
    int unsigned     n;
    logic [VW-1:0]   v;
    b = sb.base();
    case ($urandom_range(7))
      0: v = $urandom_range(20);
      1: v = {VW{1'b1}} - $urandom_range(3);
      2: begin
        pw = 1;
        n = $urandom_range(32);
        repeat (n) begin
          if (pw * b <= 64'hFFFF_FFFF) begin
            pw = pw * b;
          end
        end
        v = pw[VW-1:0] - $urandom_range(1);
      end
      3: v = 32'd1 << $urandom_range(VW - 1);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    logic [RADIX_W-1:0] phase_radix [NUM_PHASES];
    int unsigned        idle_pct [4];
    phase_radix = '{5'd2, 5'd16, 5'd3, 5'd0, 5'd31, 5'd10, 5'd17, 5'd7, 5'd1};
    idle_pct = '{0, 53, 0, 7};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset radix of ten, then binary, hex, clamped settings and base three.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1000000000);
    drain();
    write_radix(5'd2);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1);
    send_value(32'd0);
    drain();
    write_radix(5'd16);
    send_value(32'hFFFF_FFFF);
    send_value(32'd15);
    send_value(32'd16);
    send_value(32'hDEAD_BEEF);
    send_value(32'h0123_4567);
    drain();
    write_radix(5'd0);
    send_value(32'd5);
    drain();
    write_radix(5'd1);
    send_value(32'd6);
    drain();
    write_radix(5'd17);
    send_value(32'd255);
    drain();
    write_radix(5'd31);
    send_value(32'hABCD_EF01);
    drain();
    write_radix(5'd3);
    send_value(32'hFFFF_FFFF);
    drain();

    // Random phases, each under its own radix setting; sender idle rates cycle through four values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 7) begin
        write_radix(RADIX_W'($urandom_range(31)));
      end else begin
        write_radix(phase_radix[p]);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_gap(idle_pct[p % 4]);
        send_value(random_value());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d digits under %0d radix settings",
             sb.values_seen, sb.digits_seen, settings_used);
    $display("%0d mismatches, %0d digits still pending", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- radix_digit_emitter.f -----
src/rde_pkg.sv
src/rde_ram.sv
src/rde_front.sv
src/rde_back.sv
src/radix_digit_emitter.sv
test/tb_radix_digit_emitter.sv
